// ===== src/dual_core_load_estimator_assert.svh =====
// assertion macros for the load estimator, clocked on clk and disabled in reset
`ifndef DUAL_CORE_LOAD_ESTIMATOR_ASSERT_SVH
`define DUAL_CORE_LOAD_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DCLE_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DCLE_CHECK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DCLE_CHECK_IMP(lbl, ante, cons)
`define DCLE_CHECK_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/dcle_pkg.sv =====
package dcle_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int RATE_W  = 32;
  localparam int BUSY_W  = 15;
  localparam int SCALE_W = 7;   // bits of the percent scale 100
  localparam int MS_W    = 10;  // bits of the 1000 ms per second factor

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd50;

  localparam logic OP_BASELINE = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  typedef enum logic [1:0] {
    ST_MEASURED = 2'd0,
    ST_SHORT    = 2'd1,
    ST_PRIMING  = 2'd2,
    ST_BASELINE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_RUN,
    TS_HOLD
  } top_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_RATE,
    LN_PEAK,
    LN_LAUNCH,
    LN_BUSY
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic capture;
    logic prime;
  } lane_cmd_t;

  typedef struct packed {
    logic              active;
    logic [BUSY_W-1:0] busy;
  } lane_stat_t;

endpackage

// ===== src/dcle_div.sv =====
module dcle_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           ge;

  // restoring step, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r, q_r[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = ~diff[DEN_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      q_r   <= num_i;
      rem_r <= '0;
      den_r <= den_i;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;

endmodule

// ===== src/dcle_lane.sv =====
module dcle_lane #(
  parameter int COUNT_WIDTH   = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dcle_pkg::lane_cmd_t          cmd_i,
  input  logic [COUNT_WIDTH-1:0]       count_i,
  input  logic [dcle_pkg::TIME_W-1:0]  elapsed_i,
  output dcle_pkg::lane_stat_t         stat_o
);

  localparam int RATE_NUM_W = COUNT_WIDTH + dcle_pkg::MS_W;
  localparam int BUSY_NUM_W = dcle_pkg::RATE_W + dcle_pkg::SCALE_W + FRACTION_BITS;
  localparam int NUM_W      = (RATE_NUM_W > BUSY_NUM_W) ? RATE_NUM_W : BUSY_NUM_W;
  localparam int RW         = dcle_pkg::RATE_W;

  dcle_pkg::lane_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0]      prev_count_r;
  logic [RW-1:0]               peak_r;
  logic [RW-1:0]               rate_r;
  logic [dcle_pkg::BUSY_W-1:0] busy_r;
  logic                        prime_r;

  logic [COUNT_WIDTH-1:0] delta;
  logic [NUM_W-1:0]       delta_ext;
  logic [NUM_W-1:0]       rate_num;
  logic [RW-1:0]          diff;
  logic [NUM_W-1:0]       diff_ext;
  logic [NUM_W-1:0]       busy_num;
  logic [RW-1:0]          rate_sat;
  logic                   start_sample;

  logic                         div_start;
  logic [NUM_W-1:0]             div_num;
  logic [dcle_pkg::TIME_W-1:0]  div_den;
  logic                         div_done;
  logic [NUM_W-1:0]             div_quot;

  always_comb begin
    delta     = count_i - prev_count_r;
    delta_ext = {{(NUM_W - COUNT_WIDTH){1'b0}}, delta};
    // times 1000 as 1024 - 16 - 8
    rate_num  = (delta_ext << 10) - (delta_ext << 4) - (delta_ext << 3);
    diff      = peak_r - rate_r;
    diff_ext  = {{(NUM_W - RW){1'b0}}, diff};
    // times 100 as 64 + 32 + 4, then the fraction shift
    busy_num  = ((diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2)) << FRACTION_BITS;
    rate_sat  = (|div_quot[NUM_W-1:RW]) ? {RW{1'b1}} : div_quot[RW-1:0];
    start_sample = cmd_i.start & ~cmd_i.capture;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dcle_pkg::LN_IDLE: begin
        if (start_sample) state_nxt = dcle_pkg::LN_RATE;
      end
      dcle_pkg::LN_RATE: begin
        if (div_done) state_nxt = prime_r ? dcle_pkg::LN_IDLE : dcle_pkg::LN_PEAK;
      end
      dcle_pkg::LN_PEAK: begin
        state_nxt = dcle_pkg::LN_LAUNCH;
      end
      dcle_pkg::LN_LAUNCH: begin
        state_nxt = (peak_r == '0) ? dcle_pkg::LN_IDLE : dcle_pkg::LN_BUSY;
      end
      dcle_pkg::LN_BUSY: begin
        if (div_done) state_nxt = dcle_pkg::LN_IDLE;
      end
      default: begin
        state_nxt = dcle_pkg::LN_IDLE;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = busy_num;
    div_den   = peak_r;
    case (state_r)
      dcle_pkg::LN_IDLE: begin
        div_start = start_sample;
        div_num   = rate_num;
        div_den   = elapsed_i;
      end
      dcle_pkg::LN_LAUNCH: begin
        div_start = (peak_r != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    stat_o.active = (state_r != dcle_pkg::LN_IDLE);
    stat_o.busy   = busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dcle_pkg::LN_IDLE;
      prev_count_r <= '0;
      peak_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == dcle_pkg::LN_IDLE) && cmd_i.start) begin
        prev_count_r <= count_i;
      end
      if ((state_r == dcle_pkg::LN_RATE) && div_done && prime_r) begin
        peak_r <= rate_sat;
      end
      if ((state_r == dcle_pkg::LN_PEAK) && (rate_r > peak_r)) begin
        peak_r <= rate_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == dcle_pkg::LN_IDLE) && cmd_i.start) prime_r <= cmd_i.prime;
    if ((state_r == dcle_pkg::LN_RATE) && div_done) rate_r <= rate_sat;
    if ((state_r == dcle_pkg::LN_LAUNCH) && (peak_r == '0)) busy_r <= '0;
    if ((state_r == dcle_pkg::LN_BUSY) && div_done) busy_r <= div_quot[dcle_pkg::BUSY_W-1:0];
  end

  dcle_div #(
    .NUM_W (NUM_W),
    .DEN_W (dcle_pkg::TIME_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule

// ===== src/dual_core_load_estimator.sv =====
// with out_ready high: baselines and too-short samples go from idle straight to hold, where
// out_valid is registered; priming samples first run the rate division in both lanes, and
// measured samples run it, raise the peak, then run the busy-share division if the peak is
// nonzero; each runs N = max(COUNT_WIDTH+10, 39+FRACTION_BITS) steps, one quotient bit a cycle
// throughput: one word at a time, the next is accepted the cycle after the result is registered
// reset: synchronous active-low rst_n clears stored point, peaks, primed flag; interval is 50
`include "dual_core_load_estimator_assert.svh"

module dual_core_load_estimator #(
  parameter int COUNT_WIDTH   = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,

  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,

  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [dcle_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [COUNT_WIDTH-1:0]       in_idle_count_core0,
  input  logic [COUNT_WIDTH-1:0]       in_idle_count_core1,

  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dcle_pkg::BUSY_W-1:0]  out_busy_core0,
  output logic [dcle_pkg::BUSY_W-1:0]  out_busy_core1,
  output logic [1:0]                   out_status
);

  dcle_pkg::top_state_t state_r, state_nxt;

  logic [dcle_pkg::CFG_W-1:0]  min_interval_r;
  logic [dcle_pkg::TIME_W-1:0] prev_time_r;
  logic                        primed_r;
  dcle_pkg::status_t           pend_status_r;

  logic                        out_valid_r;
  logic [dcle_pkg::BUSY_W-1:0] out_busy0_r;
  logic [dcle_pkg::BUSY_W-1:0] out_busy1_r;
  dcle_pkg::status_t           out_status_r;

  logic                        accept;
  logic                        is_baseline;
  logic [dcle_pkg::TIME_W-1:0] elapsed;
  logic [dcle_pkg::CFG_W-1:0]  limit;
  logic                        too_short;
  logic                        cfg_write;
  logic                        out_free;
  logic                        load_out;
  logic                        lanes_idle;

  dcle_pkg::lane_cmd_t  lane_cmd;
  dcle_pkg::lane_stat_t lane0_stat;
  dcle_pkg::lane_stat_t lane1_stat;

  // register access, single register decoded on paddr[2] low, so it answers at words zero to three
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {{(32 - dcle_pkg::CFG_W){1'b0}}, min_interval_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= dcle_pkg::MIN_INTERVAL_RST;
    end else if (cfg_write) begin
      min_interval_r <= pwdata[dcle_pkg::CFG_W-1:0];
    end
  end

  // elapsed time since the stored point, wrap-safe; a zero interval acts as one
  always_comb begin
    accept      = in_valid & in_ready;
    is_baseline = (in_operation == dcle_pkg::OP_BASELINE);
    elapsed     = in_now_ms - prev_time_r;
    limit       = (min_interval_r == '0) ? dcle_pkg::CFG_W'(1) : min_interval_r;
    too_short   = elapsed < {{(dcle_pkg::TIME_W - dcle_pkg::CFG_W){1'b0}}, limit};
    out_free    = ~out_valid_r | out_ready;
    lanes_idle  = ~lane0_stat.active & ~lane1_stat.active;
  end

  // both lanes see the same command; baseline only stores the counters
  always_comb begin
    lane_cmd.start   = accept & (is_baseline | ~too_short);
    lane_cmd.capture = is_baseline;
    lane_cmd.prime   = ~primed_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dcle_pkg::TS_IDLE: begin
        if (accept) begin
          state_nxt = (!is_baseline && !too_short) ? dcle_pkg::TS_RUN : dcle_pkg::TS_HOLD;
        end
      end
      dcle_pkg::TS_RUN: begin
        if (lanes_idle) state_nxt = dcle_pkg::TS_HOLD;
      end
      dcle_pkg::TS_HOLD: begin
        if (out_free) state_nxt = dcle_pkg::TS_IDLE;
      end
      default: begin
        state_nxt = dcle_pkg::TS_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      dcle_pkg::TS_IDLE: begin
        in_ready = 1'b1;
      end
      dcle_pkg::TS_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcle_pkg::TS_IDLE;
      prev_time_r <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (is_baseline) begin
          prev_time_r <= in_now_ms;
          primed_r    <= 1'b0;
        end else if (!too_short) begin
          prev_time_r <= in_now_ms;
          primed_r    <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending status, then the merge of both lanes into the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_baseline) begin
        pend_status_r <= dcle_pkg::ST_BASELINE;
      end else if (too_short) begin
        pend_status_r <= dcle_pkg::ST_SHORT;
      end else begin
        pend_status_r <= primed_r ? dcle_pkg::ST_MEASURED : dcle_pkg::ST_PRIMING;
      end
    end
    if (load_out) begin
      out_status_r <= pend_status_r;
      out_busy0_r  <= (pend_status_r == dcle_pkg::ST_MEASURED) ? lane0_stat.busy : '0;
      out_busy1_r  <= (pend_status_r == dcle_pkg::ST_MEASURED) ? lane1_stat.busy : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_busy_core0 = out_busy0_r;
  assign out_busy_core1 = out_busy1_r;
  assign out_status     = out_status_r;

  // one lane per core
  dcle_lane #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (lane_cmd),
    .count_i   (in_idle_count_core0),
    .elapsed_i (elapsed),
    .stat_o    (lane0_stat)
  );

  dcle_lane #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (lane_cmd),
    .count_i   (in_idle_count_core1),
    .elapsed_i (elapsed),
    .stat_o    (lane1_stat)
  );

  // a word in flight blocks the next one
  `DCLE_CHECK_NXT(a_accept_blocks, accept, !in_ready)
  // lanes only work while the controller waits on them
  `DCLE_CHECK_IMP(a_lanes_in_run, lane0_stat.active || lane1_stat.active,
                  state_r == dcle_pkg::TS_RUN)
  // only a measured word carries a busy share
  `DCLE_CHECK_IMP(a_busy_only_measured,
                  out_valid_r && (out_status_r != dcle_pkg::ST_MEASURED),
                  (out_busy0_r == '0) && (out_busy1_r == '0))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int COUNT_WIDTH   = 32;
  localparam int FRACTION_BITS = 8;
  localparam logic [63:0] FULL_SCALE = 64'd100 << FRACTION_BITS;
  localparam logic [63:0] MS_PER_S   = 64'd1000;
  // slowest word: two serial divisions of max(COUNT_WIDTH+10, 39+FRACTION_BITS) steps
  localparam int DIV_STEPS = (COUNT_WIDTH + 10 > 39 + FRACTION_BITS) ?
                             COUNT_WIDTH + 10 : 39 + FRACTION_BITS;
  localparam int RESULT_LATENCY = 2 * DIV_STEPS + 8;
  localparam int STALL_LIMIT    = 5000;
  localparam int PHASE_WORDS    = 140;

  localparam logic [2:0] ADDR_MIN_INTERVAL = 3'd0;

  // one result word as the block reports it
  typedef struct packed {
    logic [dcle_pkg::BUSY_W-1:0] busy0;
    logic [dcle_pkg::BUSY_W-1:0] busy1;
    logic [1:0]                  status;
  } load_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic                        in_valid            = 1'b0;
  logic                        in_ready;
  logic                        in_operation        = dcle_pkg::OP_BASELINE;
  logic [dcle_pkg::TIME_W-1:0] in_now_ms           = '0;
  logic [COUNT_WIDTH-1:0]      in_idle_count_core0 = '0;
  logic [COUNT_WIDTH-1:0]      in_idle_count_core1 = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [dcle_pkg::BUSY_W-1:0] out_busy_core0;
  logic [dcle_pkg::BUSY_W-1:0] out_busy_core1;
  logic [1:0]                  out_status;

  dual_core_load_estimator #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_now_ms          (in_now_ms),
    .in_idle_count_core0(in_idle_count_core0),
    .in_idle_count_core1(in_idle_count_core1),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_busy_core0     (out_busy_core0),
    .out_busy_core1     (out_busy_core1),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: own copy of the stored point, peaks and interval register
  // ---------------------------------------------------------------------------
  logic [dcle_pkg::CFG_W-1:0]  min_interval_q = dcle_pkg::MIN_INTERVAL_RST;
  logic [dcle_pkg::TIME_W-1:0] stored_time    = '0;
  logic [COUNT_WIDTH-1:0]      stored_count0  = '0;
  logic [COUNT_WIDTH-1:0]      stored_count1  = '0;
  logic [dcle_pkg::RATE_W-1:0] peak_rate0     = '0;
  logic [dcle_pkg::RATE_W-1:0] peak_rate1     = '0;
  logic                        peaks_primed   = 1'b0;

  load_result_t busy_expected[$];

  int mismatches     = 0;
  int n_baseline     = 0;
  int n_short        = 0;
  int n_priming      = 0;
  int n_measured     = 0;
  int n_settings     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // idle hits per second, floor(delta*1000/elapsed), saturated to the rate width
  function automatic logic [dcle_pkg::RATE_W-1:0] rate_per_second(
      logic [COUNT_WIDTH-1:0] delta, logic [dcle_pkg::TIME_W-1:0] elapsed);
    logic [63:0] scaled;
    scaled = (64'(delta) * MS_PER_S) / 64'(elapsed);
    if (scaled > 64'(32'hFFFF_FFFF)) return '1;
    return scaled[dcle_pkg::RATE_W-1:0];
  endfunction

  // busy share against a peak that has already been raised to the rate
  function automatic logic [dcle_pkg::BUSY_W-1:0] busy_share(
      logic [dcle_pkg::RATE_W-1:0] rate, logic [dcle_pkg::RATE_W-1:0] peak);
    logic [63:0] share;
    if (peak == '0) return '0;
    share = (64'(peak - rate) * FULL_SCALE) / 64'(peak);
    return share[dcle_pkg::BUSY_W-1:0];
  endfunction

  function automatic load_result_t predict_load(logic op, logic [dcle_pkg::TIME_W-1:0] now,
                                                logic [COUNT_WIDTH-1:0] c0,
                                                logic [COUNT_WIDTH-1:0] c1);
    load_result_t                res;
    logic [dcle_pkg::TIME_W-1:0] limit;
    logic [dcle_pkg::TIME_W-1:0] elapsed;
    logic [COUNT_WIDTH-1:0]      d0;
    logic [COUNT_WIDTH-1:0]      d1;
    logic [dcle_pkg::RATE_W-1:0] r0;
    logic [dcle_pkg::RATE_W-1:0] r1;
    res = '0;
    // an interval register of zero behaves like one
    limit = (min_interval_q == '0) ? 32'd1 : 32'(min_interval_q);
    if (op == dcle_pkg::OP_BASELINE) begin
      stored_time   = now;
      stored_count0 = c0;
      stored_count1 = c1;
      peaks_primed  = 1'b0;
      res.status    = dcle_pkg::ST_BASELINE;
      n_baseline++;
    end else begin
      elapsed = now - stored_time;
      if (elapsed < limit) begin
        // too soon: nothing stored, nothing reported
        res.status = dcle_pkg::ST_SHORT;
        n_short++;
      end else begin
        d0 = c0 - stored_count0;
        d1 = c1 - stored_count1;
        stored_time   = now;
        stored_count0 = c0;
        stored_count1 = c1;
        r0 = rate_per_second(d0, elapsed);
        r1 = rate_per_second(d1, elapsed);
        if (!peaks_primed) begin
          peak_rate0   = r0;
          peak_rate1   = r1;
          peaks_primed = 1'b1;
          res.status   = dcle_pkg::ST_PRIMING;
          n_priming++;
        end else begin
          if (r0 > peak_rate0) peak_rate0 = r0;
          if (r1 > peak_rate1) peak_rate1 = r1;
          res.busy0  = busy_share(r0, peak_rate0);
          res.busy1  = busy_share(r1, peak_rate1);
          res.status = dcle_pkg::ST_MEASURED;
          n_measured++;
        end
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_val, act_val);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    load_result_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (busy_expected.size() == 0) begin
        note_mismatch("result word with none expected", 32'd0, 32'(out_status));
      end else begin
        exp_word = busy_expected.pop_front();
        if (out_busy_core0 !== exp_word.busy0)
          note_mismatch("busy_core0", 32'(exp_word.busy0), 32'(out_busy_core0));
        if (out_busy_core1 !== exp_word.busy1)
          note_mismatch("busy_core1", 32'(exp_word.busy1), 32'(out_busy_core1));
        if (out_status !== exp_word.status)
          note_mismatch("status", 32'(exp_word.status), 32'(out_status));
      end
    end
  end

  // watchdog: cycles in which no word moves on any channel
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", stall_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks, each entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  // offer one input word, possibly after a random gap; valid stays high on return
  task automatic send_word(logic op, logic [dcle_pkg::TIME_W-1:0] now,
                           logic [COUNT_WIDTH-1:0] c0, logic [COUNT_WIDTH-1:0] c1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_now_ms           <= now;
    in_idle_count_core0 <= c0;
    in_idle_count_core1 <= c1;
    do @(posedge clk); while (!in_ready);
    busy_expected.push_back(predict_load(op, now, c0, c1));
  endtask

  // sender holds off until every outstanding word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (busy_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the interval register while the block is idle, then read it back
  task automatic set_min_interval(logic [dcle_pkg::CFG_W-1:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MIN_INTERVAL;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_interval_q = value;
    n_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[dcle_pkg::CFG_W-1:0] !== value)
      note_mismatch("min_interval_ms read-back", 32'(value),
                    32'(prdata[dcle_pkg::CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // samples before any baseline work against the all-zero reset point
  task automatic test_reset_point();
    send_word(dcle_pkg::OP_SAMPLE, 32'd0,   32'd0,    32'd0);     // too short at reset
    send_word(dcle_pkg::OP_SAMPLE, 32'd50,  32'd1000, 32'd2000);  // primes both peaks
    send_word(dcle_pkg::OP_SAMPLE, 32'd100, 32'd1500, 32'd4000);  // half idle on core zero
    send_word(dcle_pkg::OP_SAMPLE, 32'd149, 32'd1600, 32'd4100);  // one ms short
    send_word(dcle_pkg::OP_SAMPLE, 32'd200, 32'd9000, 32'd4100);  // raises peak zero
    send_word(dcle_pkg::OP_SAMPLE, 32'd250, 32'd9000, 32'd4100);  // no idle hits at all
  endtask

  // time and counter wrap, and a peak that stays at zero
  task automatic test_wrap_and_zero_peak();
    send_word(dcle_pkg::OP_BASELINE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FF00);
    send_word(dcle_pkg::OP_SAMPLE,   32'h0000_0040, 32'h0000_0010, 32'h0000_0100);
    send_word(dcle_pkg::OP_SAMPLE,   32'h0000_0090, 32'h0000_0010, 32'h0000_0200);
    send_word(dcle_pkg::OP_BASELINE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(dcle_pkg::OP_SAMPLE,   32'h0000_0032, 32'h0000_0000, 32'h0000_0000);
    send_word(dcle_pkg::OP_SAMPLE,   32'h0000_0064, 32'h0000_0000, 32'h0000_0000);
  endtask

  // interval register at zero, one and full scale, with saturating rates
  task automatic test_interval_extremes();
    logic [dcle_pkg::CFG_W-1:0]  values[3];
    logic [dcle_pkg::TIME_W-1:0] eff;
    logic [dcle_pkg::TIME_W-1:0] t0;
    values = '{16'd0, 16'd1, 16'hFFFF};
    foreach (values[k]) begin
      set_min_interval(values[k]);
      eff = (values[k] == '0) ? 32'd1 : 32'(values[k]);
      t0  = $urandom;
      send_word(dcle_pkg::OP_BASELINE, t0, 32'd0, 32'hFFFF_FFFF);
      send_word(dcle_pkg::OP_SAMPLE, t0 + eff - 1, 32'h1234, 32'h5678);
      send_word(dcle_pkg::OP_SAMPLE, t0 + eff, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(dcle_pkg::OP_SAMPLE, t0 + 2 * eff, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      if (values[k] == 16'hFFFF)
        send_word(dcle_pkg::OP_SAMPLE, t0 + 2 * eff - 1, 32'hFFFF_FFFD, 32'hFFFF_FFFE);
    end
  endtask

  // idle-counter delta for one core over the given elapsed time
  function automatic logic [COUNT_WIDTH-1:0] pick_delta(logic [31:0] base_rate,
                                                        logic [dcle_pkg::TIME_W-1:0] elapsed);
    int          kind;
    logic [63:0] hits;
    kind = $urandom_range(99);
    if (kind < 5) return '0;
    if (kind < 15) return $urandom;
    hits = (64'(base_rate) * 64'($urandom_range(110))) / 64'd100;
    hits = (hits * 64'(elapsed)) / MS_PER_S;
    return hits[COUNT_WIDTH-1:0];
  endfunction

  // a phase of mostly well-formed sample streams with baselines mixed in
  task automatic run_load_phase(int n_words);
    logic [31:0]                 base0;
    logic [31:0]                 base1;
    logic [dcle_pkg::TIME_W-1:0] eff;
    logic [dcle_pkg::TIME_W-1:0] elapsed;
    int                          pick;
    int                          drain_at;
    base0    = $urandom_range(200000);
    base1    = $urandom_range(200000);
    eff      = (min_interval_q == '0) ? 32'd1 : 32'(min_interval_q);
    drain_at = $urandom_range(3 * n_words / 4, n_words / 4);
    for (int i = 0; i < n_words; i++) begin
      if (i == drain_at) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(dcle_pkg::OP_BASELINE, $urandom, $urandom, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 15)
          elapsed = (eff > 1) ? $urandom_range(eff - 1) : 32'd0;
        else if (pick < 25)
          elapsed = eff;
        else if (pick < 85)
          elapsed = eff + $urandom_range(2 * eff + 100);
        else
          elapsed = $urandom;
        send_word(dcle_pkg::OP_SAMPLE, stored_time + elapsed,
                  stored_count0 + pick_delta(base0, elapsed),
                  stored_count1 + pick_delta(base1, elapsed));
      end
    end
  endtask

  // sweep idling patterns and interval settings, extremes included
  task automatic test_random_load();
    logic [dcle_pkg::CFG_W-1:0] setting;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 6;  recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int p = 0; p < 4; p++) begin
        case (p)
          0: setting = 16'd1;
          1: setting = 16'hFFFF;
          2: setting = 16'($urandom_range(2000, 2));
          default: setting = (mode == 1) ? 16'd0 : dcle_pkg::MIN_INTERVAL_RST;
        endcase
        set_min_interval(setting);
        run_load_phase(PHASE_WORDS);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with a moderately stalling receiver
    send_idle_pct = 6;
    recv_idle_pct = 57;
    test_reset_point();
    test_wrap_and_zero_peak();
    test_interval_extremes();
    test_random_load();

    wait_for_results();
    repeat (RESULT_LATENCY) @(posedge clk);
    if (busy_expected.size() != 0) begin
      $display("%0d result words never arrived", busy_expected.size());
      mismatches += busy_expected.size();
    end

    $display("covered %0d baselines and %0d samples over %0d interval settings",
             n_baseline, n_short + n_priming + n_measured, n_settings);
    $display("samples: %0d too short, %0d priming, %0d measured; %0d mismatches",
             n_short, n_priming, n_measured, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
